@@ design/fct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants for the frustum cull tester.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int FIELD_W         = 32;
  localparam int NUM_PLANES_DEF  = 6;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int PLANE_IDX_W     = 3;
  localparam int SLOT_W          = 3;
  localparam int IN_DATA_W       = 232;
  localparam int IN_USER_W       = 3;
  localparam int OUT_DATA_W      = 8;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_SPHERE = 2'd2,
    CMD_BOX    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

@@ design/frustum_cull_tester_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_tester_core
// Frustum test of points, spheres and boxes against NUM_PLANES stored planes.
//
// Channel  Dir  Handshake          Contents
// s_*      in   tvalid/tready      tuser: command, box_is_null; tdata: slot, coords
// m_*      out  tvalid/tready      tdata: visible, culling_plane
//
// Plane write: no result.
// Query: one plane is read from the plane store per cycle into a four-stage
//   multiply/max/sum pipe.
// Null box: no plane reads.
// Reset clears the plane valid bits, so unwritten planes read as zero.
// A finished result waits in the output register; the block stalls in its
// final state only while a previous result is still untaken.
// ----------------------------------------------------------------------------
module frustum_cull_tester_core
  import fct_pkg::*;
#(
  parameter int NUM_PLANES  = NUM_PLANES_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // plane_slot, first_x, first_y, first_z, second_x, second_y, second_z,
  // extra_value, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // command, box_is_null
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // visible, culling_plane, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int PW   = 2 * CW;
  localparam int SW   = 2 * CW + 3;
  localparam int RW   = 4 * CW;
  localparam logic [AW-1:0] LAST = AW'(NUM_PLANES - 1);
  localparam logic [PLANE_IDX_W-1:0] NONE = PLANE_IDX_W'(NUM_PLANES);

  // input unpacking
  cmd_t              in_cmd;
  logic              in_null;
  logic [SLOT_W-1:0] in_slot;
  logic [CW-1:0]     in_ax, in_ay, in_az, in_bx, in_by, in_bz, in_ex;

  assign in_cmd  = cmd_t'(s_tuser[1:0]);
  assign in_null = s_tuser[2];
  assign in_slot = s_tdata[2:0];
  assign in_ax   = s_tdata[3 + 0*FIELD_W +: CW];
  assign in_ay   = s_tdata[3 + 1*FIELD_W +: CW];
  assign in_az   = s_tdata[3 + 2*FIELD_W +: CW];
  assign in_bx   = s_tdata[3 + 3*FIELD_W +: CW];
  assign in_by   = s_tdata[3 + 4*FIELD_W +: CW];
  assign in_bz   = s_tdata[3 + 5*FIELD_W +: CW];
  assign in_ex   = s_tdata[3 + 6*FIELD_W +: CW];

  state_t state;
  logic   accept;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // plane store
  logic                  wr_en;
  logic [NUM_PLANES-1:0] plane_ok;
  logic [RW-1:0]         rd_data;
  logic [AW-1:0]         issue_cnt;
  logic                  issuing;

  assign wr_en = accept && (in_cmd == CMD_WRITE) &&
                 ({1'b0, in_slot} < (SLOT_W + 1)'(NUM_PLANES));

  fct_ram #(
    .WIDTH(RW),
    .DEPTH(NUM_PLANES),
    .AW   (AW)
  ) u_planes (
    .clk  (clk),
    .we   (wr_en),
    .waddr(in_slot[AW-1:0]),
    .wdata({in_ex, in_az, in_ay, in_ax}),
    .raddr(issue_cnt),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_ok <= '0;
    end else if (wr_en) begin
      plane_ok[in_slot[AW-1:0]] <= 1'b1;
    end
  end

  // query operands
  logic signed [CW-1:0] ax, ay, az, bx, by, bz, ex;

  always_ff @(posedge clk) begin
    if (accept) begin
      ax <= in_ax;
      ay <= in_ay;
      az <= in_az;
      bx <= (in_cmd == CMD_BOX) ? in_bx : in_ax;
      by <= (in_cmd == CMD_BOX) ? in_by : in_ay;
      bz <= (in_cmd == CMD_BOX) ? in_bz : in_az;
      ex <= (in_cmd == CMD_SPHERE) ? in_ex : '0;
    end
  end

  // pipe stage 1: read data
  logic          v1, ok1;
  logic [AW-1:0] i1;
  logic signed [CW-1:0] nx, ny, nz, no;

  assign nx = ok1 ? $signed(rd_data[0*CW +: CW]) : '0;
  assign ny = ok1 ? $signed(rd_data[1*CW +: CW]) : '0;
  assign nz = ok1 ? $signed(rd_data[2*CW +: CW]) : '0;
  assign no = ok1 ? $signed(rd_data[3*CW +: CW]) : '0;

  // pipe stage 2: products
  logic                   v2;
  logic [AW-1:0]          i2;
  logic signed [PW-1:0]   pax, pbx, pay, pby, paz, pbz;
  logic signed [CW:0]     oe2;

  // pipe stage 3: per-axis maximum (worst corner)
  logic                   v3;
  logic [AW-1:0]          i3;
  logic signed [PW-1:0]   mx, my, mz;
  logic signed [CW:0]     oe3;

  // pipe stage 4: sign of distance
  logic                   v4, below4;
  logic [AW-1:0]          i4;
  logic signed [SW-1:0]   dsum;

  assign dsum = SW'(mx) + SW'(my) + SW'(mz) + (SW'(oe3) <<< 16);

  always_ff @(posedge clk) begin
    ok1    <= plane_ok[issue_cnt];
    i1     <= issue_cnt;
    i2     <= i1;
    i3     <= i2;
    i4     <= i3;
    pax    <= nx * ax;
    pbx    <= nx * bx;
    pay    <= ny * ay;
    pby    <= ny * by;
    paz    <= nz * az;
    pbz    <= nz * bz;
    oe2    <= (CW + 1)'(no) + (CW + 1)'(ex);
    mx     <= (pax > pbx) ? pax : pbx;
    my     <= (pay > pby) ? pay : pby;
    mz     <= (paz > pbz) ? paz : pbz;
    oe3    <= oe2;
    below4 <= dsum[SW-1];
  end

  // control
  logic                   found, null_q;
  logic [PLANE_IDX_W-1:0] cull;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issuing   <= 1'b0;
      issue_cnt <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      found     <= 1'b0;
      null_q    <= 1'b0;
      cull      <= NONE;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
    end else begin
      v1 <= issuing;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      if (issuing) begin
        if (issue_cnt == LAST) begin
          issuing <= 1'b0;
        end else begin
          issue_cnt <= issue_cnt + AW'(1);
        end
      end
      case (state)
        ST_IDLE: begin
          if (accept && (in_cmd != CMD_WRITE)) begin
            found  <= 1'b0;
            cull   <= NONE;
            null_q <= (in_cmd == CMD_BOX) && in_null;
            if ((in_cmd == CMD_BOX) && in_null) begin
              state <= ST_FIN;
            end else begin
              state     <= ST_RUN;
              issuing   <= 1'b1;
              issue_cnt <= '0;
            end
          end
        end
        ST_RUN: begin
          if (v4) begin
            if (below4 && !found) begin
              found <= 1'b1;
              cull  <= PLANE_IDX_W'(i4);
            end
            if (i4 == LAST) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0000, cull, !found && !null_q};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(v1 || v2 || v3 || v4 || issuing))
    else $error("plane pipe busy while idle");

  a_last_finishes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && v4 && i4 == LAST) |=> (state == ST_FIN))
    else $error("last plane did not finish query");

  a_cull_range: assert property (@(posedge clk) disable iff (rst)
    found |-> ({1'b0, cull} < (PLANE_IDX_W + 1)'(NUM_PLANES)))
    else $error("culling plane out of range");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd != CMD_WRITE && !(in_cmd == CMD_BOX && in_null))
    |=> (state == ST_RUN && issuing && issue_cnt == '0))
    else $error("query did not start plane scan");

  a_null_no_cull: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && null_q) |-> !found)
    else $error("null box reported a culling plane");

endmodule

@@ design/fct_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
